[rtl/core/tgr_pkg.sv]
// Package for the text glyph renderer: panel and font constants, item structs
// and the 8x16 glyph table. Depends on nothing; every module uses it.

package tgr_pkg;

    localparam int PANEL_WIDTH  = 160;
    localparam int PANEL_HEIGHT = 110;

    localparam int CURSOR_W    = 16;
    localparam int COLOUR_W    = 16;
    localparam int CHAR_W      = 8;
    localparam int WIN_X_W     = 8;
    localparam int WIN_Y_W     = 7;
    localparam int GLYPH_W     = 8;
    localparam int GLYPH_H     = 16;
    localparam int ROW_W       = $clog2(GLYPH_H);
    localparam int GLYPH_COUNT = 41;
    localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
    localparam int HALF_COLS   = GLYPH_W / 2;
    localparam int HALF_W      = HALF_COLS * COLOUR_W;
    localparam int ADVANCE_X   = 9;
    localparam int LINE_STEP_Y = 18;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int GLYPH_ALPHA_BASE = 10;
    localparam int GLYPH_SPACE      = 36;
    localparam int GLYPH_BANG       = 37;
    localparam int GLYPH_COLON      = 38;
    localparam int GLYPH_PERIOD     = 39;
    localparam int GLYPH_DASH       = 40;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_BANG    = 8'h21;
    localparam logic [CHAR_W-1:0] CHAR_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PERIOD  = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_COLON   = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

    typedef enum logic [0:0] {
        CFG_FORE_COLOUR = 1'b0,
        CFG_BACK_COLOUR = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [CHAR_W-1:0]   char_code;
        logic                new_string;
        logic [CURSOR_W-1:0] origin_x;
        logic [CURSOR_W-1:0] origin_y;
    } t_in_item;

    typedef struct packed {
        logic [WIN_X_W-1:0] win_x_start;
        logic [WIN_Y_W-1:0] win_y_start;
        logic [WIN_X_W-1:0] win_x_end;
        logic [WIN_Y_W-1:0] win_y_end;
        logic [ROW_W-1:0]   glyph_row;
        logic [HALF_W-1:0]  pixels_left;
        logic [HALF_W-1:0]  pixels_right;
        logic               last_row;
    } t_out_item;

    typedef struct packed {
        logic [GLYPH_IDX_W-1:0] glyph;
        logic [WIN_X_W-1:0]     x_start;
        logic [WIN_Y_W-1:0]     y_start;
        logic [WIN_X_W-1:0]     x_end;
        logic [WIN_Y_W-1:0]     y_end;
    } t_cmd;

    typedef struct packed {
        logic [COLOUR_W-1:0] fore;
        logic [COLOUR_W-1:0] back;
    } t_colours;

    // Element GLYPH_H-1 holds the top row of the glyph.
    typedef logic [GLYPH_H-1:0][GLYPH_W-1:0] t_glyph;

    function automatic t_glyph tgr_glyph(input logic [GLYPH_IDX_W-1:0] idx);
        t_glyph g;
        unique case (idx)
            6'd0:  g = 128'h001C2241_41414141_41414141_221C0000;
            6'd1:  g = 128'h00081828_08080808_08080808_081C0000;
            6'd2:  g = 128'h003C4281_01010204_08102040_80FF0000;
            6'd3:  g = 128'h007E8101_01020C02_01010101_827C0000;
            6'd4:  g = 128'h00060A0A_12222242_4282FF02_02020000;
            6'd5:  g = 128'h00FF8080_80BCC201_01010101_827C0000;
            6'd6:  g = 128'h001F2040_40809CA2_C1818181_423C0000;
            6'd7:  g = 128'h00FF8102_02040408_08101020_20400000;
            6'd8:  g = 128'h003C4281_8181423C_42818181_423C0000;
            6'd9:  g = 128'h003C4281_81818143_21110905_02000000;
            6'd10: g = 128'h00182442_42427E42_42424242_00000000;
            6'd11: g = 128'h007C4242_42427C42_4242427C_00000000;
            6'd12: g = 128'h003C4280_80808080_8080423C_00000000;
            6'd13: g = 128'h007C4242_42424242_4242427C_00000000;
            6'd14: g = 128'h007E4040_40407C40_4040407E_00000000;
            6'd15: g = 128'h007E4040_40407C40_40404040_00000000;
            6'd16: g = 128'h003C4280_80808E82_8282423C_00000000;
            6'd17: g = 128'h00424242_42427E42_42424242_00000000;
            6'd18: g = 128'h007C1010_10101010_1010107C_00000000;
            6'd19: g = 128'h001F0404_04040404_04444438_00000000;
            6'd20: g = 128'h00424448_50606050_48444242_00000000;
            6'd21: g = 128'h00404040_40404040_4040407E_00000000;
            6'd22: g = 128'h0082C6C6_AAAA9292_82828282_00000000;
            6'd23: g = 128'h00426262_52524A4A_46464242_00000000;
            6'd24: g = 128'h003C4281_81818181_8181423C_00000000;
            6'd25: g = 128'h007C4242_42427C40_40404040_00000000;
            6'd26: g = 128'h003C4281_81818181_9189463D_01000000;
            6'd27: g = 128'h007C4242_42427C48_44444242_00000000;
            6'd28: g = 128'h003C4280_80601C02_0101423C_00000000;
            6'd29: g = 128'h00FE1010_10101010_10101010_00000000;
            6'd30: g = 128'h00424242_42424242_4242423C_00000000;
            6'd31: g = 128'h00424242_24242418_18181818_00000000;
            6'd32: g = 128'h00828282_929292AA_AA444444_00000000;
            6'd33: g = 128'h00424224_24181818_24244242_00000000;
            6'd34: g = 128'h00824444_28281010_10101010_00000000;
            6'd35: g = 128'h007E0204_08081020_2040407E_00000000;
            6'd36: g = 128'h00000000_00000000_00000000_00000000;
            6'd37: g = 128'h00181818_18181818_18000018_18000000;
            6'd38: g = 128'h00000000_00181800_00000018_18000000;
            6'd39: g = 128'h00000000_00000000_00000018_18000000;
            6'd40: g = 128'h00000000_0000007E_7E000000_00000000;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

[rtl/core/tgr_front.sv]
// Front end of the text glyph renderer: accepts character items, keeps the
// text cursor, picks the glyph and clamps the window. Depends on tgr_pkg.

module tgr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tgr_pkg::t_in_item i_in_item,
    input  logic              i_q_full,
    output logic              o_push,
    output tgr_pkg::t_cmd     o_cmd
);

    localparam int CW = tgr_pkg::CURSOR_W;
    localparam int XW = tgr_pkg::WIN_X_W;
    localparam int YW = tgr_pkg::WIN_Y_W;
    localparam int IW = tgr_pkg::GLYPH_IDX_W;

    logic [CW-1:0] r_cursor_x, n_cursor_x;
    logic [CW-1:0] r_cursor_y, n_cursor_y;
    logic [CW-1:0] r_home_x,   n_home_x;

    logic [CW-1:0] eff_x, eff_y, eff_home, end_x, end_y;
    logic [IW-1:0] glyph;
    logic          drawable;
    logic          accept;
    logic [tgr_pkg::CHAR_W-1:0] c;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign c          = i_in_item.char_code;

    always_comb begin
        eff_x    = i_in_item.new_string ? i_in_item.origin_x : r_cursor_x;
        eff_y    = i_in_item.new_string ? i_in_item.origin_y : r_cursor_y;
        eff_home = i_in_item.new_string ? i_in_item.origin_x : r_home_x;
        end_x    = CW'(eff_x + CW'(tgr_pkg::GLYPH_W - 1));
        end_y    = CW'(eff_y + CW'(tgr_pkg::GLYPH_H - 1));
    end

    always_comb begin
        drawable = 1'b1;
        glyph    = '0;
        priority if (c >= tgr_pkg::CHAR_ZERO && c <= tgr_pkg::CHAR_NINE) begin
            glyph = IW'(c - tgr_pkg::CHAR_ZERO);
        end else if (c >= tgr_pkg::CHAR_UPPER_A && c <= tgr_pkg::CHAR_UPPER_Z) begin
            glyph = IW'(c - tgr_pkg::CHAR_UPPER_A + tgr_pkg::CHAR_W'(tgr_pkg::GLYPH_ALPHA_BASE));
        end else if (c >= tgr_pkg::CHAR_LOWER_A && c <= tgr_pkg::CHAR_LOWER_Z) begin
            glyph = IW'(c - tgr_pkg::CHAR_LOWER_A + tgr_pkg::CHAR_W'(tgr_pkg::GLYPH_ALPHA_BASE));
        end else if (c == tgr_pkg::CHAR_SPACE) begin
            glyph = IW'(tgr_pkg::GLYPH_SPACE);
        end else if (c == tgr_pkg::CHAR_BANG) begin
            glyph = IW'(tgr_pkg::GLYPH_BANG);
        end else if (c == tgr_pkg::CHAR_COLON) begin
            glyph = IW'(tgr_pkg::GLYPH_COLON);
        end else if (c == tgr_pkg::CHAR_PERIOD) begin
            glyph = IW'(tgr_pkg::GLYPH_PERIOD);
        end else if (c == tgr_pkg::CHAR_DASH) begin
            glyph = IW'(tgr_pkg::GLYPH_DASH);
        end else begin
            drawable = 1'b0;
        end
    end

    always_comb begin
        o_cmd.glyph   = glyph;
        o_cmd.x_start = (eff_x >= CW'(tgr_pkg::PANEL_WIDTH))
                        ? XW'(tgr_pkg::PANEL_WIDTH - 1) : eff_x[XW-1:0];
        o_cmd.y_start = (eff_y >= CW'(tgr_pkg::PANEL_HEIGHT))
                        ? YW'(tgr_pkg::PANEL_HEIGHT - 1) : eff_y[YW-1:0];
        o_cmd.x_end   = (end_x >= CW'(tgr_pkg::PANEL_WIDTH))
                        ? XW'(tgr_pkg::PANEL_WIDTH - 1) : end_x[XW-1:0];
        o_cmd.y_end   = (end_y >= CW'(tgr_pkg::PANEL_HEIGHT))
                        ? YW'(tgr_pkg::PANEL_HEIGHT - 1) : end_y[YW-1:0];
        o_push        = accept && drawable;
    end

    always_comb begin
        n_cursor_x = r_cursor_x;
        n_cursor_y = r_cursor_y;
        n_home_x   = r_home_x;
        if (accept) begin
            n_home_x = eff_home;
            if (c == tgr_pkg::CHAR_NEWLINE) begin
                n_cursor_x = eff_home;
                n_cursor_y = CW'(eff_y + CW'(tgr_pkg::LINE_STEP_Y));
            end else begin
                n_cursor_x = CW'(eff_x + CW'(tgr_pkg::ADVANCE_X));
                n_cursor_y = eff_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= '0;
            r_cursor_y <= '0;
            r_home_x   <= '0;
        end else begin
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
            r_home_x   <= n_home_x;
        end
    end

endmodule

[rtl/core/tgr_queue.sv]
// Short command queue between the front and back ends of the text glyph
// renderer. Depends on tgr_pkg.

module tgr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tgr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output tgr_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    localparam int D  = tgr_pkg::QUEUE_DEPTH;
    localparam int PW = tgr_pkg::QPTR_W;
    localparam int NW = tgr_pkg::QCNT_W;

    tgr_pkg::t_cmd r_mem [D];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [NW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == NW'(D));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(D - 1)) ? '0 : PW'(r_wr_ptr + 1'b1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(D - 1)) ? '0 : PW'(r_rd_ptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= NW'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= NW'(r_count - 1'b1);
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count <= NW'(D))
        else $error("Queue count exceeds its depth.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && !i_pop) |=> !o_empty)
        else $error("Queue empty after a push without a pop.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty && !i_push) |=> !o_full)
        else $error("Queue full after a pop without a push.");

endmodule

[rtl/core/tgr_back.sv]
// Back end of the text glyph renderer: takes glyph commands from the queue and
// emits sixteen pixel rows each through an output register. Depends on tgr_pkg.

module tgr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tgr_pkg::t_cmd      i_cmd,
    input  logic               i_q_empty,
    output logic               o_pop,
    input  tgr_pkg::t_colours  i_colours,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tgr_pkg::t_out_item o_out_item
);

    localparam int RW = tgr_pkg::ROW_W;
    localparam int CW = tgr_pkg::COLOUR_W;
    localparam int HC = tgr_pkg::HALF_COLS;

    logic               r_busy, n_busy;
    logic [RW-1:0]      r_row;
    tgr_pkg::t_cmd      r_cmd;
    tgr_pkg::t_glyph    r_glyph;
    logic               r_out_valid;
    tgr_pkg::t_out_item r_out;

    logic                        adv, emit, finishing;
    logic [tgr_pkg::GLYPH_W-1:0] bits;
    tgr_pkg::t_out_item          row_item;

    assign adv       = !r_out_valid || i_out_ready;
    assign emit      = r_busy && adv;
    assign finishing = emit && (r_row == RW'(tgr_pkg::GLYPH_H - 1));
    assign o_pop     = !i_q_empty && (!r_busy || finishing);
    assign bits      = r_glyph[~r_row];

    always_comb begin
        n_busy = r_busy;
        if (o_pop) begin
            n_busy = 1'b1;
        end else if (finishing) begin
            n_busy = 1'b0;
        end
    end

    always_comb begin
        row_item.win_x_start = r_cmd.x_start;
        row_item.win_y_start = r_cmd.y_start;
        row_item.win_x_end   = r_cmd.x_end;
        row_item.win_y_end   = r_cmd.y_end;
        row_item.glyph_row   = r_row;
        row_item.last_row    = (r_row == RW'(tgr_pkg::GLYPH_H - 1));
        for (int k = 0; k < HC; k++) begin
            row_item.pixels_left[(HC-1-k)*CW +: CW] =
                bits[tgr_pkg::GLYPH_W-1-k] ? i_colours.fore : i_colours.back;
            row_item.pixels_right[(HC-1-k)*CW +: CW] =
                bits[HC-1-k] ? i_colours.fore : i_colours.back;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd   <= i_cmd;
            r_glyph <= tgr_pkg::tgr_glyph(i_cmd.glyph);
        end
        if (emit) begin
            r_out <= row_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (o_pop) begin
                r_row <= '0;
            end else if (emit) begin
                r_row <= RW'(r_row + 1'b1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) !r_busy |-> r_row == '0)
        else $error("Row counter left nonzero while no character is in work.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_pop |=> r_busy)
        else $error("Back end idle after taking a command.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last_row) |-> r_busy)
        else $error("Character dropped before its last row.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !o_pop) |=> r_row == RW'($past(r_row) + 1'b1))
        else $error("Row counter skipped a row.");

endmodule

[rtl/core/text_glyph_renderer.sv]
// Top level of the text glyph renderer: colour registers, front end, command
// queue and back end. Depends on tgr_pkg, tgr_front, tgr_queue and tgr_back.
//
// Usage: each input item carries one character. With new_string set, the
// origin is loaded into the cursor and line home column first. Digits, letters
// (either case) and space ! : . - produce sixteen output items, one per glyph
// row, top row first, each with the clamped window and eight RGB565 pixels;
// last_row marks the sixteenth. A newline moves down 18 rows to the line home
// column and produces nothing; other characters produce nothing but advance.
// An accepted character passes the command queue, the back end's command
// register and the output register before its first row leaves. The back
// end emits one row per cycle while the receiver keeps taking them.
// The front end keeps accepting while the two-entry command queue
// has room, so a stalled receiver only blocks input once the queue is full.
// The output register holds its item until taken. Reset clears the cursor,
// the queue and the output, and sets the colours to white on black. Colour
// writes take effect at once and are meant for idle periods only.

module text_glyph_renderer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tgr_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tgr_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_index,
    input  logic [tgr_pkg::COLOUR_W-1:0]  i_cfg_data
);

    tgr_pkg::t_colours r_colours;
    tgr_pkg::t_cmd     push_cmd, head_cmd;
    logic              push, pop, q_full, q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colours.fore <= '1;
            r_colours.back <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (tgr_pkg::t_cfg_reg'(i_cfg_index))
                tgr_pkg::CFG_FORE_COLOUR: r_colours.fore <= i_cfg_data;
                tgr_pkg::CFG_BACK_COLOUR: r_colours.back <= i_cfg_data;
            endcase
        end
    end

    tgr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    tgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tgr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .i_colours   (r_colours),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
